// ----- rtl/png_scanline_unfilter_rgba8_defines.svh -----
// Assertion macros shared by the unfilter block.
`ifndef PNG_SCANLINE_UNFILTER_RGBA8_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_RGBA8_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLKD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- rtl/pngu_pkg.sv -----
`timescale 1ns / 1ps

package pngu_pkg;

	localparam int MAX_ROW_BYTES = 8192;
	localparam int RB_W          = 14;
	localparam int ROWS_W        = 16;
	localparam int CNT_W         = $clog2(MAX_ROW_BYTES + 1);
	localparam int IDX_W         = $clog2(MAX_ROW_BYTES);
	localparam int CMP_W         = (RB_W > CNT_W) ? RB_W : CNT_W;
	localparam int MIN_ROW_BYTES = 4;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic REG_ROW_BYTES  = 1'b0;
	localparam logic REG_IMAGE_ROWS = 1'b1;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       last_in_row;
		logic       last_in_image;
		logic       bad_filter;
	} out_word_t;

	function automatic logic [9:0] absdiff(input logic [9:0] x, input logic [9:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

	// estimate a + b - c, with every term offset by c to stay unsigned
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [9:0] p;
		logic [9:0] da;
		logic [9:0] db;
		logic [9:0] dc;
		p  = {2'b00, a} + {2'b00, b};
		da = absdiff(p, {2'b00, a} + {2'b00, c});
		db = absdiff(p, {2'b00, b} + {2'b00, c});
		dc = absdiff(p, {2'b00, c} + {2'b00, c});
		if (da <= db && da <= dc) begin
			return a;
		end else if (db <= dc) begin
			return b;
		end
		return c;
	endfunction

endpackage

// ----- rtl/png_scanline_unfilter_rgba8.sv -----
`timescale 1ns / 1ps
// PNG scanline unfilter, 8-bit RGBA.
// Slave stream: one inflated byte per word; the first byte of each row is the
// filter type, then row_bytes filtered samples. tuser marks the first byte
// of an image and restarts the counters and clears a held error.
// Master stream: one rebuilt sample per word, tlast on the final byte of a
// row, tuser flags the final byte of the image and a bad filter type. A
// filter byte gives no word; a type above 4 gives one error word and every
// byte is dropped until the next image start.
// One byte is accepted every cycle while s_tready is high. The row above sits
// in a single-port-read RAM that is read one sample ahead, so its registered
// read is ready when the sample arrives.
// An output register plus a one-word skid stage keeps tready high while one
// word waits; input tready drops only once both are full.
// Reset: row_bytes = 4, image_rows = 1, counters and error cleared, block
// expects the filter byte of row 0. The row RAM is not cleared; row 0 ignores
// it, and later rows read what the row above wrote unless row_bytes grows.
// APB: row_bytes at 0x0, image_rows at 0x4, pready always high.
`include "png_scanline_unfilter_rgba8_defines.svh"

module png_scanline_unfilter_rgba8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] raw_byte
	input  logic [0:0]  s_tuser,   // [0] start_image
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pixel_byte
	output logic        m_tlast,
	output logic [1:0]  m_tuser,   // [0] last_in_image, [1] bad_filter
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = pngu_pkg::CNT_W;
	localparam int IDX_W = pngu_pkg::IDX_W;
	localparam int CMP_W = pngu_pkg::CMP_W;
	localparam int ROWS_W = pngu_pkg::ROWS_W;
	localparam int RB_W = pngu_pkg::RB_W;

	logic [RB_W-1:0]   row_bytes_q;
	logic [ROWS_W-1:0] image_rows_q;

	logic [CNT_W-1:0]  col_q, col_d, col_c;
	logic [ROWS_W-1:0] row_q, row_d, row_c, row_inc;
	logic [2:0]        filt_q, filt_d;
	logic              err_q, err_d, err_c;
	logic [31:0]       left_q, left_d, left_c;
	logic [31:0]       upl_q, upl_d, upl_c;

	logic [7:0]        mem [pngu_pkg::MAX_ROW_BYTES];
	logic [7:0]        mem_rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic              mem_we;

	logic [CMP_W-1:0]  rb_eff;
	logic [ROWS_W-1:0] rows_eff;
	logic              acc, start, active, is_filt, bad, sample, end_row, end_image;
	logic [7:0]        raw, left, up, upleft, pred, val;
	logic [8:0]        avg_sum;

	pngu_pkg::out_word_t res_w, out_q, skid_q;
	logic                out_v_q, skid_v_q, res_v;

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			pngu_pkg::REG_ROW_BYTES:  prdata = {{(32-RB_W){1'b0}}, row_bytes_q};
			pngu_pkg::REG_IMAGE_ROWS: prdata = {{(32-ROWS_W){1'b0}}, image_rows_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= RB_W'(pngu_pkg::MIN_ROW_BYTES);
			image_rows_q <= ROWS_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				pngu_pkg::REG_ROW_BYTES:  row_bytes_q  <= pwdata[RB_W-1:0];
				pngu_pkg::REG_IMAGE_ROWS: image_rows_q <= pwdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp registers to their working range
	always_comb begin
		rb_eff = CMP_W'(row_bytes_q);
		if (rb_eff < CMP_W'(pngu_pkg::MIN_ROW_BYTES)) begin
			rb_eff = CMP_W'(pngu_pkg::MIN_ROW_BYTES);
		end
		if (rb_eff > CMP_W'(pngu_pkg::MAX_ROW_BYTES)) begin
			rb_eff = CMP_W'(pngu_pkg::MAX_ROW_BYTES);
		end
		rows_eff = (image_rows_q == '0) ? ROWS_W'(1) : image_rows_q;
	end

	assign s_tready = !skid_v_q;
	assign acc      = s_tvalid && s_tready;
	assign start    = s_tuser[0];
	assign raw      = s_tdata;

	assign col_c  = start ? '0 : col_q;
	assign row_c  = start ? '0 : row_q;
	assign err_c  = start ? 1'b0 : err_q;
	assign left_c = start ? '0 : left_q;
	assign upl_c  = start ? '0 : upl_q;

	assign active  = !err_c && (row_c < rows_eff);
	assign is_filt = (col_c == '0);
	assign bad     = active && is_filt && (raw > 8'(pngu_pkg::FILT_PAETH));
	assign sample  = active && !is_filt;

	assign left    = left_c[31:24];
	assign upleft  = upl_c[31:24];
	assign up      = (row_c != '0) ? mem_rd_q : 8'h00;
	assign avg_sum = {1'b0, left} + {1'b0, up};

	always_comb begin
		case (filt_q)
			pngu_pkg::FILT_SUB:   pred = left;
			pngu_pkg::FILT_UP:    pred = up;
			pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
			pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(left, up, upleft);
			default:              pred = 8'h00;
		endcase
	end

	assign val       = raw + pred;
	assign end_row   = CMP_W'(col_c) >= rb_eff;
	assign row_inc   = row_c + ROWS_W'(1);
	assign end_image = row_inc >= rows_eff;

	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		filt_d = filt_q;
		err_d  = err_q;
		left_d = left_q;
		upl_d  = upl_q;
		if (acc) begin
			col_d  = col_c;
			row_d  = row_c;
			err_d  = err_c;
			left_d = left_c;
			upl_d  = upl_c;
			if (bad) begin
				err_d = 1'b1;
			end else if (active && is_filt) begin
				filt_d = raw[2:0];
				col_d  = CNT_W'(1);
			end else if (sample) begin
				if (end_row) begin
					row_d  = row_inc;
					col_d  = '0;
					left_d = '0;
					upl_d  = '0;
				end else begin
					col_d  = col_c + CNT_W'(1);
					left_d = {left_c[23:0], val};
					upl_d  = {upl_c[23:0], up};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			filt_q <= pngu_pkg::FILT_NONE;
			err_q  <= 1'b0;
			left_q <= '0;
			upl_q  <= '0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			filt_q <= filt_d;
			err_q  <= err_d;
			left_q <= left_d;
			upl_q  <= upl_d;
		end
	end

	// row above: write this sample, prefetch the one for the next state
	assign mem_we  = acc && sample;
	assign wr_addr = IDX_W'(col_c - CNT_W'(1));
	assign rd_addr = (col_d == '0) ? '0 : IDX_W'(col_d - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= val;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// result word and output register with skid stage
	always_comb begin
		res_w.pixel_byte    = sample ? val : 8'h00;
		res_w.last_in_row   = sample && end_row;
		res_w.last_in_image = sample && end_row && end_image;
		res_w.bad_filter    = bad;
	end
	assign res_v = acc && (bad || sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q  <= skid_v_q || res_v;
			skid_v_q <= 1'b0;
		end else if (res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res_w;
		end else if (res_v) begin
			skid_q <= res_w;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_q.pixel_byte;
	assign m_tlast    = out_q.last_in_row;
	assign m_tuser[0] = out_q.last_in_image;
	assign m_tuser[1] = out_q.bad_filter;

	`ASSERT_CLKD(a_skid_needs_out, !skid_v_q || out_v_q, "skid word without output word")
	`ASSERT_CLKD(a_bad_word_clean, !(m_tvalid && m_tuser[1]) || (m_tdata == 8'h00 && !m_tlast && !m_tuser[0]), "error word carries data")
	`ASSERT_CLKD(a_col_in_range, col_q <= CNT_W'(pngu_pkg::MAX_ROW_BYTES), "column count past row limit")
	`ASSERT_CLKD(a_err_drops, !(err_q && !s_tuser[0]) || !res_v, "word produced during held error")

endmodule

// ----- test/tb_png_scanline_unfilter_rgba8.sv -----
`timescale 1ns / 1ps

module tb_png_scanline_unfilter_rgba8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	png_scanline_unfilter_rgba8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [13:0] cfg_rb = 14'd4;
	logic [15:0] cfg_rows = 16'd1;
	logic [7:0]  row_above [pngu_pkg::MAX_ROW_BYTES];
	logic [31:0] left_hist = 32'd0;
	logic [31:0] upleft_hist = 32'd0;
	int unsigned col_cnt = 0;
	logic [15:0] rows_done = 16'd0;
	logic [2:0]  cur_filter = pngu_pkg::FILT_NONE;
	bit          err_hold = 1'b0;

	pngu_pkg::out_word_t pixel_q [$];
	int unsigned taken_bytes = 0;
	int unsigned fail_count = 0;
	bit          idling = 1'b0;
	int unsigned sink_hold = 0;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		int ia, ib, ic, est, pa, pb, pc;
		ia = a;
		ib = b;
		ic = c;
		est = ia + ib - ic;
		pa = est - ia;
		pb = est - ib;
		pc = est - ic;
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_sample();
		logic [7:0] corner [7];
		corner = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd254, 8'd255};
		if ($urandom_range(0, 3) == 0) begin
			return corner[$urandom_range(0, 6)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic unfilter_byte(input logic [7:0] raw, input bit first);
		int unsigned rb_eff, rows_eff, idx;
		logic [7:0] left, up, upleft, val;
		pngu_pkg::out_word_t w;
		bit row_end;
		rb_eff = (cfg_rb < 4) ? 4 : (cfg_rb > pngu_pkg::MAX_ROW_BYTES) ?
			pngu_pkg::MAX_ROW_BYTES : cfg_rb;
		rows_eff = (cfg_rows == 0) ? 1 : cfg_rows;
		if (first) begin
			col_cnt = 0;
			left_hist = 32'd0;
			upleft_hist = 32'd0;
			rows_done = 16'd0;
			err_hold = 1'b0;
		end
		if (err_hold || rows_done >= rows_eff) return;
		taken_bytes++;
		if (col_cnt == 0) begin
			if (raw > pngu_pkg::FILT_PAETH) begin
				err_hold = 1'b1;
				w = '{pixel_byte: 8'd0, last_in_row: 1'b0, last_in_image: 1'b0,
					bad_filter: 1'b1};
				pixel_q.push_back(w);
				return;
			end
			cur_filter = raw[2:0];
			col_cnt = 1;
			return;
		end
		idx = col_cnt - 1;
		left = left_hist[31:24];
		upleft = upleft_hist[31:24];
		up = (rows_done != 0) ? row_above[idx] : 8'd0;
		case (cur_filter)
			pngu_pkg::FILT_SUB: val = raw + left;
			pngu_pkg::FILT_UP: val = raw + up;
			pngu_pkg::FILT_AVG: val = raw + 8'((9'(left) + 9'(up)) >> 1);
			pngu_pkg::FILT_PAETH: val = raw + paeth_pick(left, up, upleft);
			default: val = raw;
		endcase
		row_above[idx] = val;
		left_hist = {left_hist[23:0], val};
		upleft_hist = {upleft_hist[23:0], up};
		row_end = (col_cnt >= rb_eff);
		w = '{pixel_byte: val, last_in_row: row_end, last_in_image: 1'b0, bad_filter: 1'b0};
		if (row_end) begin
			rows_done = rows_done + 16'd1;
			w.last_in_image = (rows_done >= rows_eff);
			col_cnt = 0;
			left_hist = 32'd0;
			upleft_hist = 32'd0;
		end else begin
			col_cnt++;
		end
		pixel_q.push_back(w);
	endtask

	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= (sink_hold == 1);
		end else if (idling && $urandom_range(0, 9) == 0) begin
			sink_hold <= $urandom_range(1, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pngu_pkg::out_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				$error("pixel word with nothing expected: pixel_byte %0h", m_tdata);
				fail_count++;
			end else begin
				want = pixel_q.pop_front();
				if (m_tdata !== want.pixel_byte) begin
					$error("pixel_byte: expected %0h, got %0h", want.pixel_byte, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.last_in_row) begin
					$error("last_in_row: expected %0b, got %0b", want.last_in_row, m_tlast);
					fail_count++;
				end
				if (m_tuser[0] !== want.last_in_image) begin
					$error("last_in_image: expected %0b, got %0b", want.last_in_image,
						m_tuser[0]);
					fail_count++;
				end
				if (m_tuser[1] !== want.bad_filter) begin
					$error("bad_filter: expected %0b, got %0b", want.bad_filter, m_tuser[1]);
					fail_count++;
				end
			end
		end
	end

	task automatic check_reg(input logic idx, input logic [31:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("%s readback: expected %0d, got %0d",
				(idx == pngu_pkg::REG_ROW_BYTES) ? "row_bytes" : "image_rows", want, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == pngu_pkg::REG_ROW_BYTES) begin
			cfg_rb = value[13:0];
		end else begin
			cfg_rows = value[15:0];
		end
		check_reg(idx, (idx == pngu_pkg::REG_ROW_BYTES) ? {18'd0, cfg_rb} : {16'd0, cfg_rows});
	endtask

	task automatic push_byte(input logic [7:0] raw, input bit first);
		if (idling && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		unfilter_byte(raw, first);
	endtask

	task automatic send_row(input logic [7:0] filt, input int unsigned count, input bit first);
		push_byte(filt, first);
		repeat (count) push_byte(pick_sample(), 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pixel_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_reset_state();
		check_reg(pngu_pkg::REG_ROW_BYTES, 32'd4);
		check_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd1);
		push_byte(pngu_pkg::FILT_NONE, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd128, 1'b0);
		push_byte(8'd1, 1'b0);
		push_byte(8'd77, 1'b0);
		wait_drained();
	endtask

	task automatic test_directed_filters();
		logic [7:0] sub_row [8];
		logic [7:0] paeth_row [8];
		sub_row = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd1, 8'd255, 8'd255, 8'd127};
		paeth_row = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd0, 8'd128, 8'd2, 8'd255};
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd8);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd3);
		push_byte(pngu_pkg::FILT_SUB, 1'b1);
		foreach (sub_row[i]) push_byte(sub_row[i], 1'b0);
		push_byte(pngu_pkg::FILT_PAETH, 1'b0);
		foreach (paeth_row[i]) push_byte(paeth_row[i], 1'b0);
		push_byte(pngu_pkg::FILT_AVG, 1'b0);
		repeat (8) push_byte(8'd255, 1'b0);
		wait_drained();
	endtask

	task automatic test_bad_filter();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd4);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd2);
		send_row(pngu_pkg::FILT_NONE, 4, 1'b1);
		push_byte(8'd5, 1'b0);
		repeat (3) push_byte(pick_sample(), 1'b0);
		push_byte(8'd255, 1'b1);
		push_byte(pngu_pkg::FILT_NONE, 1'b0);
		push_byte(8'd8, 1'b1);
		repeat (2) push_byte(pick_sample(), 1'b0);
		wait_drained();
	endtask

	task automatic test_register_limits();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd0);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd0);
		send_row(pngu_pkg::FILT_SUB, 4, 1'b1);
		push_byte(pick_sample(), 1'b0);
		wait_drained();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd3);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd2);
		send_row(pngu_pkg::FILT_NONE, 4, 1'b1);
		send_row(pngu_pkg::FILT_UP, 4, 1'b0);
		wait_drained();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd6);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd3);
		send_row(pngu_pkg::FILT_AVG, 6, 1'b1);
		send_row(pngu_pkg::FILT_PAETH, 6, 1'b0);
		send_row(pngu_pkg::FILT_SUB, 6, 1'b0);
		wait_drained();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd4);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd65535);
		send_row(pngu_pkg::FILT_NONE, 4, 1'b1);
		send_row(pngu_pkg::FILT_PAETH, 4, 1'b0);
		send_row(pngu_pkg::FILT_AVG, 4, 1'b0);
		wait_drained();
	endtask

	task automatic test_mid_image_change();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd12);
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd4);
		send_row(pngu_pkg::FILT_UP, 12, 1'b1);
		send_row(pngu_pkg::FILT_PAETH, 6, 1'b0);
		wait_drained();
		write_reg(pngu_pkg::REG_ROW_BYTES, 32'd4);
		push_byte(pick_sample(), 1'b0);
		send_row(pngu_pkg::FILT_SUB, 4, 1'b0);
		wait_drained();
		write_reg(pngu_pkg::REG_IMAGE_ROWS, 32'd2);
		repeat (3) push_byte(pick_sample(), 1'b0);
		wait_drained();
	endtask

	task automatic test_random_images(input int unsigned target);
		int unsigned goal, rb_eff, rows_eff, r, cut;
		logic [13:0] rb;
		logic [15:0] rows;
		logic [31:0] junk;
		logic [7:0] filt;
		bit closed;
		closed = 1'b1;
		goal = taken_bytes + target;
		while (taken_bytes < goal) begin
			case ($urandom_range(0, 9))
				0: rb = 14'($urandom_range(0, 3));
				1: rb = 14'($urandom_range(40, 120));
				default: rb = 14'($urandom_range(4, 24));
			endcase
			rows = ($urandom_range(0, 9) == 0) ? 16'd0 :
				(rb > 24) ? 16'($urandom_range(1, 2)) : 16'($urandom_range(1, 5));
			junk = $urandom();
			write_reg(pngu_pkg::REG_ROW_BYTES, {junk[31:14], rb});
			junk = $urandom();
			write_reg(pngu_pkg::REG_IMAGE_ROWS, {junk[31:16], rows});
			rb_eff = (rb < 4) ? 4 : rb;
			rows_eff = (rows == 0) ? 1 : rows;
			// stray bytes only when the last image closed, so no row above is read unwritten
			if (closed && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3)) push_byte(pick_sample(), 1'b0);
			end
			closed = 1'b1;
			for (r = 0; r < rows_eff && closed; r++) begin
				filt = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(5, 255)) :
					8'($urandom_range(0, 4));
				push_byte(filt, r == 0);
				if (filt > pngu_pkg::FILT_PAETH) begin
					repeat ($urandom_range(0, 2)) push_byte(pick_sample(), 1'b0);
					break;
				end
				cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, rb_eff - 1) : rb_eff;
				repeat (cut) push_byte(pick_sample(), 1'b0);
				if (cut < rb_eff) closed = 1'b0;
			end
			wait_drained();
		end
	endtask

	task automatic test_steady_stream();
		idling = 1'b0;
		test_random_images(320);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling = 1'b1;
		test_reset_state();
		test_directed_filters();
		test_bad_filter();
		test_register_limits();
		test_mid_image_change();
		test_random_images(880);
		test_steady_stream();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pngu_pkg.sv
rtl/png_scanline_unfilter_rgba8.sv
test/tb_png_scanline_unfilter_rgba8.sv
